>>> sv/qrs_pkg.sv
package qrs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int THR_W      = 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int DISC_W = 2 * DATA_WIDTH + 2;
    localparam int SQ_W   = DATA_WIDTH + 1;
    localparam int DEN_W  = DATA_WIDTH + 1;
    localparam int NUM_W  = DATA_WIDTH + 2;
    localparam int SN_W   = DATA_WIDTH + 3;
    localparam int THP_W  = THR_W + DEN_W;
    localparam int SQS_W  = SQ_W + FRAC_BITS;
    localparam int CMP_W  = (SQS_W > THP_W) ? SQS_W : THP_W;
    localparam int DV_W   = DEN_W + DATA_WIDTH;
    localparam int OVF_W  = DEN_W + DATA_WIDTH - FRAC_BITS;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] CNT_NONE = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    // classified request handed from front to back
    typedef struct packed {
        logic                  degen;
        logic                  dneg;
        logic [DISC_W-1:0]     disc;
        logic [DATA_WIDTH-1:0] mb;
        logic                  nb;
        logic                  na;
        logic [DATA_WIDTH-1:0] ma;
    } t_fq;

endpackage

>>> sv/qrs_front.sv
module qrs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [qrs_pkg::DATA_WIDTH-1:0]   i_coef_a,
    input  logic [qrs_pkg::DATA_WIDTH-1:0]   i_coef_b,
    input  logic [qrs_pkg::DATA_WIDTH-1:0]   i_coef_c,
    input  logic                             i_full,
    output logic                             o_push,
    output qrs_pkg::t_fq                     o_entry
);
    import qrs_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] ma;
        logic [DATA_WIDTH-1:0] mb;
        logic [DATA_WIDTH-1:0] mc;
        logic                  na;
        logic                  nb;
        logic                  nc;
    } t_s1;

    typedef struct packed {
        logic [PROD_W-1:0]     bb;
        logic [PROD_W-1:0]     ac;
        logic [DATA_WIDTH-1:0] ma;
        logic [DATA_WIDTH-1:0] mb;
        logic                  na;
        logic                  nb;
        logic                  nc;
    } t_s2;

    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_fq  r_s3, n_s3;
    logic w_en;

    logic [DISC_W-1:0] w_bb, w_fac;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
    endfunction

    assign w_en    = !r_v3 || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_v3 && !i_full;
    assign o_entry = r_s3;

    always_comb begin
        n_s1.ma = mag(i_coef_a);
        n_s1.mb = mag(i_coef_b);
        n_s1.mc = mag(i_coef_c);
        n_s1.na = i_coef_a[DATA_WIDTH-1];
        n_s1.nb = i_coef_b[DATA_WIDTH-1];
        n_s1.nc = i_coef_c[DATA_WIDTH-1];
    end

    always_comb begin
        n_s2.bb = PROD_W'(r_s1.mb) * PROD_W'(r_s1.mb);
        n_s2.ac = PROD_W'(r_s1.ma) * PROD_W'(r_s1.mc);
        n_s2.ma = r_s1.ma;
        n_s2.mb = r_s1.mb;
        n_s2.na = r_s1.na;
        n_s2.nb = r_s1.nb;
        n_s2.nc = r_s1.nc;
    end

    assign w_bb  = DISC_W'(r_s2.bb);
    assign w_fac = {r_s2.ac, 2'b00};

    always_comb begin
        n_s3.degen = (r_s2.ma == '0);
        n_s3.mb    = r_s2.mb;
        n_s3.nb    = r_s2.nb;
        n_s3.na    = r_s2.na;
        n_s3.ma    = r_s2.ma;
        if (r_s2.na != r_s2.nc) begin
            n_s3.dneg = 1'b0;
            n_s3.disc = w_bb + w_fac;
        end else begin
            n_s3.dneg = (w_bb < w_fac);
            n_s3.disc = w_bb - w_fac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

endmodule

>>> sv/qrs_queue.sv
module qrs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qrs_pkg::t_fq  i_entry,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output qrs_pkg::t_fq  o_head
);
    import qrs_pkg::*;

    t_fq              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt;
    logic             w_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

endmodule

>>> sv/qrs_back.sv
module qrs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  qrs_pkg::t_fq                     i_q_head,
    output logic                             o_q_pop,
    input  logic [qrs_pkg::THR_W-1:0]        i_thr,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [qrs_pkg::CNT_W-1:0]        o_root_count,
    output logic [qrs_pkg::DATA_WIDTH-1:0]   o_first_root,
    output logic [qrs_pkg::DATA_WIDTH-1:0]   o_second_root,
    output logic                             o_degenerate,
    output logic                             o_saturated
);
    import qrs_pkg::*;

    typedef struct packed {
        logic                  degen;
        logic                  dneg;
        logic [DISC_W-1:0]     rem;
        logic [SQ_W-1:0]       root;
        logic [DATA_WIDTH-1:0] mb;
        logic                  nb;
        logic                  na;
        logic [DATA_WIDTH-1:0] ma;
    } t_sq;

    typedef struct packed {
        logic                  degen;
        logic                  dneg;
        logic [THP_W-1:0]      prod;
        logic [SQS_W-1:0]      sshift;
        logic [SN_W-1:0]       n1;
        logic [SN_W-1:0]       n2;
        logic [DATA_WIDTH-1:0] mb;
        logic                  nb;
        logic                  na;
        logic [DEN_W-1:0]      den;
    } t_t1;

    typedef struct packed {
        logic                  degen;
        logic                  dneg;
        logic                  one;
        logic                  neg1;
        logic                  neg2;
        logic                  ovf1;
        logic                  ovf2;
        logic [DV_W-1:0]       rem1;
        logic [DV_W-1:0]       rem2;
        logic [DATA_WIDTH-1:0] q1;
        logic [DATA_WIDTH-1:0] q2;
        logic [DEN_W-1:0]      den;
    } t_dv;

    logic w_en;

    t_sq  w_sq_in [SQ_W];
    t_sq  r_sq    [SQ_W];
    logic r_sv    [SQ_W];

    t_t1  r_t1, n_t1;
    logic r_t1v;

    t_dv  w_dv_in [DATA_WIDTH+1];
    t_dv  r_dv    [DATA_WIDTH+1];
    logic r_dvv   [DATA_WIDTH+1];

    logic                  r_out_v;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_r1, n_r1, r_r2, n_r2;
    logic                  r_degen, r_sat, n_sat;

    assign w_en    = !r_out_v || i_ready;
    assign o_q_pop = w_en;

    // square root, one result bit per stage
    always_comb begin
        w_sq_in[0].degen = i_q_head.degen;
        w_sq_in[0].dneg  = i_q_head.dneg;
        w_sq_in[0].rem   = i_q_head.disc;
        w_sq_in[0].root  = '0;
        w_sq_in[0].mb    = i_q_head.mb;
        w_sq_in[0].nb    = i_q_head.nb;
        w_sq_in[0].na    = i_q_head.na;
        w_sq_in[0].ma    = i_q_head.ma;
    end

    for (genvar k = 0; k < SQ_W; k++) begin : g_sq
        localparam int B = SQ_W - 1 - k;
        t_sq                n_sq;
        logic [DISC_W:0]    w_term;
        logic               w_ge;

        if (k > 0) begin : g_link
            assign w_sq_in[k] = r_sq[k-1];
        end

        assign w_term = ((DISC_W+1)'(w_sq_in[k].root) << (B + 1))
                      | ((DISC_W+1)'(1) << (2 * B));
        assign w_ge   = ({1'b0, w_sq_in[k].rem} >= w_term);

        always_comb begin
            n_sq = w_sq_in[k];
            if (w_ge) begin
                n_sq.rem  = w_sq_in[k].rem - w_term[DISC_W-1:0];
                n_sq.root = w_sq_in[k].root | (SQ_W'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[k] <= n_sq;
            end
        end
    end

    // threshold product and root numerators
    logic [SQ_W-1:0]  w_s;
    logic [SN_W-1:0]  w_bs, w_sx;
    logic [DEN_W-1:0] w_den;

    assign w_s   = r_sq[SQ_W-1].root;
    assign w_sx  = SN_W'(w_s);
    assign w_bs  = r_sq[SQ_W-1].nb ? (~SN_W'(r_sq[SQ_W-1].mb) + SN_W'(1))
                                   : SN_W'(r_sq[SQ_W-1].mb);
    assign w_den = {r_sq[SQ_W-1].ma, 1'b0};

    always_comb begin
        n_t1.degen  = r_sq[SQ_W-1].degen;
        n_t1.dneg   = r_sq[SQ_W-1].dneg;
        n_t1.prod   = THP_W'(i_thr) * THP_W'(w_den);
        n_t1.sshift = SQS_W'(w_s) << FRAC_BITS;
        n_t1.n1     = w_sx - w_bs;
        n_t1.n2     = (~w_bs + SN_W'(1)) - w_sx;
        n_t1.mb     = r_sq[SQ_W-1].mb;
        n_t1.nb     = r_sq[SQ_W-1].nb;
        n_t1.na     = r_sq[SQ_W-1].na;
        n_t1.den    = w_den;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1 <= n_t1;
        end
    end

    // one/two root decision, divider set-up
    logic [NUM_W-1:0] w_m1, w_m2, w_num1;
    logic             w_one, w_neg1;
    logic [OVF_W-1:0] w_lim;

    assign w_m1  = r_t1.n1[SN_W-1] ? NUM_W'(~r_t1.n1 + SN_W'(1)) : NUM_W'(r_t1.n1);
    assign w_m2  = r_t1.n2[SN_W-1] ? NUM_W'(~r_t1.n2 + SN_W'(1)) : NUM_W'(r_t1.n2);
    assign w_one = (CMP_W'(r_t1.sshift) < CMP_W'(r_t1.prod));
    assign w_lim = OVF_W'(r_t1.den) << (DATA_WIDTH - FRAC_BITS);

    always_comb begin
        if (w_one) begin
            w_num1 = NUM_W'(r_t1.mb);
            w_neg1 = ((!r_t1.nb) != r_t1.na) && (r_t1.mb != '0);
        end else begin
            w_num1 = w_m1;
            w_neg1 = (r_t1.n1[SN_W-1] != r_t1.na) && (w_m1 != '0);
        end
    end

    always_comb begin
        w_dv_in[0].degen = r_t1.degen;
        w_dv_in[0].dneg  = r_t1.dneg;
        w_dv_in[0].one   = w_one;
        w_dv_in[0].neg1  = w_neg1;
        w_dv_in[0].neg2  = (r_t1.n2[SN_W-1] != r_t1.na) && (w_m2 != '0);
        w_dv_in[0].ovf1  = (OVF_W'(w_num1) >= w_lim);
        w_dv_in[0].ovf2  = (OVF_W'(w_m2) >= w_lim);
        w_dv_in[0].rem1  = DV_W'(w_num1) << FRAC_BITS;
        w_dv_in[0].rem2  = DV_W'(w_m2) << FRAC_BITS;
        w_dv_in[0].q1    = '0;
        w_dv_in[0].q2    = '0;
        w_dv_in[0].den   = r_t1.den;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= w_dv_in[0];
        end
    end

    // two restoring dividers, one quotient bit per stage
    for (genvar j = 1; j <= DATA_WIDTH; j++) begin : g_dv
        localparam int B = DATA_WIDTH - j;
        t_dv             n_dv;
        logic [DV_W-1:0] w_d;

        assign w_dv_in[j] = r_dv[j-1];
        assign w_d        = DV_W'(w_dv_in[j].den) << B;

        always_comb begin
            n_dv = w_dv_in[j];
            if (w_dv_in[j].rem1 >= w_d) begin
                n_dv.rem1 = w_dv_in[j].rem1 - w_d;
                n_dv.q1   = w_dv_in[j].q1 | (DATA_WIDTH'(1) << B);
            end
            if (w_dv_in[j].rem2 >= w_d) begin
                n_dv.rem2 = w_dv_in[j].rem2 - w_d;
                n_dv.q2   = w_dv_in[j].q2 | (DATA_WIDTH'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[j] <= n_dv;
            end
        end
    end

    // sign, clamp, result assembly
    t_dv                   w_f;
    logic                  w_sat1, w_sat2;
    logic [DATA_WIDTH-1:0] w_v1, w_v2;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    assign w_f = r_dv[DATA_WIDTH];

    always_comb begin
        if (w_f.neg1) begin
            w_sat1 = w_f.ovf1 || (w_f.q1[DATA_WIDTH-1] && (w_f.q1[DATA_WIDTH-2:0] != '0));
            w_v1   = w_sat1 ? MAX_NEG : (~w_f.q1 + DATA_WIDTH'(1));
        end else begin
            w_sat1 = w_f.ovf1 || w_f.q1[DATA_WIDTH-1];
            w_v1   = w_sat1 ? MAX_POS : w_f.q1;
        end
        if (w_f.neg2) begin
            w_sat2 = w_f.ovf2 || (w_f.q2[DATA_WIDTH-1] && (w_f.q2[DATA_WIDTH-2:0] != '0));
            w_v2   = w_sat2 ? MAX_NEG : (~w_f.q2 + DATA_WIDTH'(1));
        end else begin
            w_sat2 = w_f.ovf2 || w_f.q2[DATA_WIDTH-1];
            w_v2   = w_sat2 ? MAX_POS : w_f.q2;
        end
    end

    always_comb begin
        priority if (w_f.degen || w_f.dneg) begin
            n_cnt = CNT_NONE;
            n_r1  = '0;
            n_r2  = '0;
            n_sat = 1'b0;
        end else if (w_f.one) begin
            n_cnt = CNT_ONE;
            n_r1  = w_v1;
            n_r2  = '0;
            n_sat = w_sat1;
        end else begin
            n_cnt = CNT_TWO;
            n_r1  = w_v1;
            n_r2  = w_v2;
            n_sat = w_sat1 || w_sat2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cnt   <= n_cnt;
            r_r1    <= n_r1;
            r_r2    <= n_r2;
            r_degen <= w_f.degen;
            r_sat   <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_W; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_t1v <= 1'b0;
            for (int j = 0; j <= DATA_WIDTH; j++) begin
                r_dvv[j] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= i_q_valid;
            for (int k = 1; k < SQ_W; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_t1v    <= r_sv[SQ_W-1];
            r_dvv[0] <= r_t1v;
            for (int j = 1; j <= DATA_WIDTH; j++) begin
                r_dvv[j] <= r_dvv[j-1];
            end
            r_out_v <= r_dvv[DATA_WIDTH];
        end
    end

    assign o_valid       = r_out_v;
    assign o_root_count  = r_cnt;
    assign o_first_root  = r_r1;
    assign o_second_root = r_r2;
    assign o_degenerate  = r_degen;
    assign o_saturated   = r_sat;

endmodule

>>> sv/quadratic_root_solver_core.sv
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_coef_a, i_coef_b, i_coef_c
// result    out        o_valid / i_ready    o_root_count, o_first_root, o_second_root,
//                                           o_degenerate, o_saturated
// config    in         i_cfg_we             i_cfg_data (near threshold)
//
// One request per cycle sustained when neither i_ready nor a full queue stalls the pipeline.
// Latency is set by the 33-stage square root and the two 32-stage dividers.
// Front (3 stages) and back run on separate stall enables, decoupled by a 4-deep queue.
// Synchronous active-low reset clears all valid flags; threshold resets to 7.
module quadratic_root_solver_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [qrs_pkg::DATA_WIDTH-1:0]   i_coef_a,
    input  logic [qrs_pkg::DATA_WIDTH-1:0]   i_coef_b,
    input  logic [qrs_pkg::DATA_WIDTH-1:0]   i_coef_c,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [qrs_pkg::CNT_W-1:0]        o_root_count,
    output logic [qrs_pkg::DATA_WIDTH-1:0]   o_first_root,
    output logic [qrs_pkg::DATA_WIDTH-1:0]   o_second_root,
    output logic                             o_degenerate,
    output logic                             o_saturated,
    input  logic                             i_cfg_we,
    input  logic [qrs_pkg::THR_W-1:0]        i_cfg_data
);
    import qrs_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             w_push, w_full, w_pop, w_qv;
    t_fq              w_entry, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    qrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_head  (w_head)
    );

    qrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_qv),
        .i_q_head      (w_head),
        .o_q_pop       (w_pop),
        .i_thr         (r_thr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_root_count  (o_root_count),
        .o_first_root  (o_first_root),
        .o_second_root (o_second_root),
        .o_degenerate  (o_degenerate),
        .o_saturated   (o_saturated)
    );

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 200;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [DW-1:0]    r1;
        logic [DW-1:0]    r2;
        logic             degen;
        logic             sat;
    } t_roots;

    typedef struct {
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] c;
        bit            typed;
        t_roots        want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [DW-1:0] i_coef_a = '0;
    logic [DW-1:0] i_coef_b = '0;
    logic [DW-1:0] i_coef_c = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [CNT_W-1:0] o_root_count;
    logic [DW-1:0] o_first_root;
    logic [DW-1:0] o_second_root;
    logic o_degenerate;
    logic o_saturated;
    logic i_cfg_we = 1'b0;
    logic [THR_W-1:0] i_cfg_data = '0;

    logic [THR_W-1:0] threshold;
    t_roots roots_due[$];
    t_row rows[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    quadratic_root_solver_core DUT (.*);

    task automatic report(input string what, input logic [DW-1:0] got,
                          input logic [DW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [DW-1:0] clamp_root(input bit neg, input logic [127:0] num,
                                                 input logic [127:0] den, inout logic sat);
        logic [127:0] q;
        q = (num << FB) / den;
        if (neg) begin
            if (q > (128'd1 << (DW - 1))) begin
                sat = 1'b1;
                return {1'b1, {(DW-1){1'b0}}};
            end
            return DW'(-q);
        end
        if (q > ((128'd1 << (DW - 1)) - 1)) begin
            sat = 1'b1;
            return {1'b0, {(DW-1){1'b1}}};
        end
        return q[DW-1:0];
    endfunction

    function automatic t_roots solve_roots(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] c,
                                           input logic [THR_W-1:0] thr);
        t_roots r;
        logic signed [129:0] disc;
        logic signed [129:0] sa, sb, sc, n1, n2;
        logic [127:0] s, den, half, bit_v, t, rem;
        bit na;
        r = '{CNT_NONE, '0, '0, 1'b0, 1'b0};
        sa = $signed(a);
        sb = $signed(b);
        sc = $signed(c);
        na = a[DW-1];
        if (a == '0) begin
            r.degen = 1'b1;
            return r;
        end
        disc = sb * sb - 4 * sa * sc;
        if (disc < 0) return r;
        rem = disc[127:0];
        s = '0;
        bit_v = 128'd1 << 126;
        while (bit_v > rem) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            t = s + bit_v;
            if (rem >= t) begin
                rem = rem - t;
                s = (s >> 1) + bit_v;
            end else begin
                s = s >> 1;
            end
            bit_v = bit_v >> 2;
        end
        den = 128'((sa < 0) ? -sa : sa) << 1;
        half = (s << FB) / den;
        if (half < thr) begin
            r.count = CNT_ONE;
            n1 = -sb;
        end else begin
            r.count = CNT_TWO;
            n1 = $signed({2'b0, s}) - sb;
        end
        n2 = -sb - $signed({2'b0, s});
        r.r1 = clamp_root((n1 < 0) != na && n1 != 0, 128'((n1 < 0) ? -n1 : n1), den, r.sat);
        if (r.count == CNT_TWO)
            r.r2 = clamp_root((n2 < 0) != na && n2 != 0, 128'((n2 < 0) ? -n2 : n2), den,
                              r.sat);
        return r;
    endfunction

    function automatic t_roots typed(input logic [CNT_W-1:0] n, input logic [DW-1:0] x,
                                     input logic [DW-1:0] y, input logic d, input logic s);
        t_roots r;
        r = '{n, x, y, d, s};
        return r;
    endfunction

    function automatic logic [DW-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return DW'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return DW'($urandom_range(0, 3)) << 30 | $urandom_range(0, 1);
            default: return DW'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    // random-length gap, mostly short
    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [DW-1:0] a, input logic [DW-1:0] b,
                        input logic [DW-1:0] c);
        i_valid <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        roots_due.push_back(solve_roots(a, b, c, threshold));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        wait (roots_due.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = v;
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 1) && k % 50 > 25) begin
                gap();
            end
            send(rand_coef(), rand_coef(), rand_coef());
        end
        i_valid <= 1'b0;
    endtask

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && i_ready) begin
                if (roots_due.size() == 0) begin
                    report("unexpected request result", o_first_root, '0);
                end else begin
                    t_roots w;
                    w = roots_due.pop_front();
                    if (o_root_count !== w.count) report("count", DW'(o_root_count), DW'(w.count));
                    if (o_first_root !== w.r1) report("first", o_first_root, w.r1);
                    if (o_second_root !== w.r2) report("second", o_second_root, w.r2);
                    if (o_degenerate !== w.degen) report("degen", DW'(o_degenerate), DW'(w.degen));
                    if (o_saturated !== w.sat) report("sat", DW'(o_saturated), DW'(w.sat));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if ($urandom_range(0, 19) == 0) i_ready <= 1'b0;
        else if ($urandom_range(0, 2) == 0) i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        threshold = THR_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rows = '{
            '{32'h0, 32'h0001_0000, 32'h0, 1'b1, typed(CNT_NONE, '0, '0, 1'b1, 1'b0)},
            '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, typed(CNT_NONE, '0, '0, 1'b1, 1'b0)},
            '{32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1, typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h0001_0000, 32'h0, 32'h0, 1'b1, typed(CNT_ONE, '0, '0, 1'b0, 1'b0)},
            '{32'h0001_0000, 32'h0, 32'hffff_0000, 1'b1,
              typed(CNT_TWO, 32'h0001_0000, 32'hffff_0000, 1'b0, 1'b0)},
            '{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h0000_0001, 32'h7fff_ffff, 32'h0, 1'b0, typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'hffff_0000, 32'h0003_0000, 32'hfffe_0000, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h0000_0002, 32'h0000_0004, 32'h0000_0002, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)},
            '{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 1'b0,
              typed(CNT_NONE, '0, '0, 1'b0, 1'b0)}
        };
        foreach (rows[k]) begin
            send(rows[k].a, rows[k].b, rows[k].c);
            if (rows[k].typed) roots_due[$] = rows[k].want;
        end
        run_random(400);
        write_threshold(16'hffff);
        send(32'h0001_0000, 32'h0, 32'h0);
        run_random(400);
        write_threshold(16'h0);
        send(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
        run_random(400);
        write_threshold(THR_W'($urandom_range(1, 300)));
        run_random(400);
        wait (roots_due.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
